// ----- sv/geffe_pkg.sv -----
// Package: Geffe cipher constants, LFSR result types and eight-step LFSR functions.
`timescale 1ns / 1ps
`default_nettype none

package geffe_pkg;

    localparam int LEN_ONE   = 26;
    localparam int LEN_TWO   = 34;
    localparam int LEN_THREE = 24;
    localparam int STEPS     = 8;

    localparam int TAP_ONE_A   = 18;
    localparam int TAP_ONE_B   = 19;
    localparam int TAP_TWO_A   = 19;
    localparam int TAP_TWO_B   = 20;
    localparam int TAP_THREE_A = 20;
    localparam int TAP_THREE_B = 21;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    // Register index codes, taken from paddr[4:3]
    localparam logic [1:0] REG_SEED_ONE   = 2'd0;
    localparam logic [1:0] REG_SEED_TWO   = 2'd1;
    localparam logic [1:0] REG_SEED_THREE = 2'd2;
    localparam logic [1:0] REG_NONE       = 2'd3;

    typedef struct packed {
        logic [LEN_ONE-1:0] state;
        logic [STEPS-1:0]   bits;
    } t_one_res;

    typedef struct packed {
        logic [LEN_TWO-1:0] state;
        logic [STEPS-1:0]   bits;
    } t_two_res;

    typedef struct packed {
        logic [LEN_THREE-1:0] state;
        logic [STEPS-1:0]     bits;
    } t_three_res;

    // Each function advances one register eight times; the first output bit lands in the MSB.
    function automatic t_one_res step_one(input logic [LEN_ONE-1:0] s);
        t_one_res r;
        logic     fb;
        r.state = s;
        r.bits  = '0;
        for (int k = 0; k < STEPS; k++) begin
            r.bits[3'(STEPS - 1 - k)] = r.state[0];
            fb = r.state[0] ^ r.state[TAP_ONE_A] ^ r.state[TAP_ONE_B] ^ r.state[LEN_ONE-1];
            r.state = {fb, r.state[LEN_ONE-1:1]};
        end
        return r;
    endfunction

    function automatic t_two_res step_two(input logic [LEN_TWO-1:0] s);
        t_two_res r;
        logic     fb;
        r.state = s;
        r.bits  = '0;
        for (int k = 0; k < STEPS; k++) begin
            r.bits[3'(STEPS - 1 - k)] = r.state[0];
            fb = r.state[0] ^ r.state[TAP_TWO_A] ^ r.state[TAP_TWO_B] ^ r.state[LEN_TWO-1];
            r.state = {fb, r.state[LEN_TWO-1:1]};
        end
        return r;
    endfunction

    function automatic t_three_res step_three(input logic [LEN_THREE-1:0] s);
        t_three_res r;
        logic       fb;
        r.state = s;
        r.bits  = '0;
        for (int k = 0; k < STEPS; k++) begin
            r.bits[3'(STEPS - 1 - k)] = r.state[0];
            fb = r.state[0] ^ r.state[TAP_THREE_A] ^ r.state[TAP_THREE_B]
                ^ r.state[LEN_THREE-1];
            r.state = {fb, r.state[LEN_THREE-1:1]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/geffe_lfsr_stream_cipher_top.sv -----
// Top level: Geffe combiner byte stream cipher with APB seed registers.
// Latency: a byte accepted at one edge shows its cipher byte at o_out_valid after that edge.
// Throughput: one byte per cycle unless stalled; each LFSR steps eight times combinationally.
// The output register accepts the next byte in the same cycle its result is taken.
// Reset (synchronous, active low): seeds and all three LFSRs go to all ones, output empty.
// Seed writes reach the LFSRs only at the next byte flagged first of message.
`timescale 1ns / 1ps
`default_nettype none

module geffe_lfsr_stream_cipher_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [geffe_pkg::ADDR_W-1:0] paddr,
    input  wire logic [geffe_pkg::DATA_W-1:0] pwdata,
    output logic      [geffe_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // input stream
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_data_byte,
    input  wire logic                        i_first_of_message,
    // output stream
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [7:0]                  o_cipher_byte
);

    logic [geffe_pkg::LEN_ONE-1:0]   r_seed_one,  r_one,   n_one,   src_one;
    logic [geffe_pkg::LEN_TWO-1:0]   r_seed_two,  r_two,   n_two,   src_two;
    logic [geffe_pkg::LEN_THREE-1:0] r_seed_three, r_three, n_three, src_three;

    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte,  n_out_byte;
    logic                in_xfer;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    geffe_pkg::t_one_res   res_one;
    geffe_pkg::t_two_res   res_two;
    geffe_pkg::t_three_res res_three;
    geffe_pkg::t_one_res   seed_res_one;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            geffe_pkg::REG_SEED_ONE:   prdata = {{(geffe_pkg::DATA_W-geffe_pkg::LEN_ONE){1'b0}},
                                                 r_seed_one};
            geffe_pkg::REG_SEED_TWO:   prdata = {{(geffe_pkg::DATA_W-geffe_pkg::LEN_TWO){1'b0}},
                                                 r_seed_two};
            geffe_pkg::REG_SEED_THREE: prdata = {{(geffe_pkg::DATA_W-geffe_pkg::LEN_THREE){1'b0}},
                                                 r_seed_three};
            geffe_pkg::REG_NONE:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_one   <= '1;
            r_seed_two   <= '1;
            r_seed_three <= '1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                geffe_pkg::REG_SEED_ONE:   r_seed_one   <= pwdata[geffe_pkg::LEN_ONE-1:0];
                geffe_pkg::REG_SEED_TWO:   r_seed_two   <= pwdata[geffe_pkg::LEN_TWO-1:0];
                geffe_pkg::REG_SEED_THREE: r_seed_three <= pwdata[geffe_pkg::LEN_THREE-1:0];
                geffe_pkg::REG_NONE:       ;
            endcase
        end
    end

    // Hold the input only while a finished result is stuck downstream.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        // Reload from the seeds before the first byte of a message.
        src_one   = i_first_of_message ? r_seed_one   : r_one;
        src_two   = i_first_of_message ? r_seed_two   : r_two;
        src_three = i_first_of_message ? r_seed_three : r_three;

        res_one   = geffe_pkg::step_one(src_one);
        res_two   = geffe_pkg::step_two(src_two);
        res_three = geffe_pkg::step_three(src_three);

        n_one       = r_one;
        n_two       = r_two;
        n_three     = r_three;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid && i_out_stall;

        if (in_xfer) begin
            n_one       = res_one.state;
            n_two       = res_two.state;
            n_three     = res_three.state;
            n_out_byte  = i_data_byte ^ ((res_one.bits & res_two.bits)
                                        | (~res_one.bits & res_three.bits));
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one       <= '1;
            r_two       <= '1;
            r_three     <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_one       <= n_one;
            r_two       <= n_two;
            r_three     <= n_three;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid   = r_out_valid;
    assign o_cipher_byte = r_out_byte;

    assign seed_res_one = geffe_pkg::step_one(r_seed_one);

    a_xfer_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_out_valid)
        else $error("accepted byte produced no result");

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> ($stable(r_one) && $stable(r_two) && $stable(r_three)))
        else $error("LFSR state moved without a transfer");

    a_reload_from_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_first_of_message)
            |=> (r_one == $past(seed_res_one.state)))
        else $error("first register not reloaded from seed");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_cipher_byte)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
